>>> hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// Audio excitement scorer package
// Shared types, constants and small lookup functions for the scorer blocks.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int Q_W          = FRAC_BITS + 1;
  localparam int SUSTAIN_BITS = 16;
  localparam int LAUGH_W      = 5;
  localparam int DIV_W        = 48;
  localparam int DIV_CNT_W    = 6;
  localparam int MA_W         = 32;
  localparam int MB_W         = 17;
  localparam int MP_W         = MA_W + MB_W;

  localparam logic [Q_W-1:0] ONE_Q       = Q_W'(1 << FRAC_BITS);
  localparam logic [Q_W-1:0] BASE_FLOOR  = Q_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [Q_W-1:0] VOICE_FLOOR = Q_W'(((1 << FRAC_BITS) + 5000) / 10000);
  localparam logic [Q_W-1:0] HIGH_EXCITE = Q_W'((95 * (1 << FRAC_BITS) + 50) / 100);
  localparam logic [SUSTAIN_BITS-1:0] SUSTAIN_MAX = '1;
  localparam logic [LAUGH_W-1:0] LAUGH_LIMIT   = 5'd30;
  localparam logic [LAUGH_W-1:0] LAUGH_SUSTAIN = 5'd8;

  typedef enum logic [2:0] {
    CFG_SLOW_ALPHA   = 3'd0,
    CFG_FAST_ALPHA   = 3'd1,
    CFG_SMOOTH_ALPHA = 3'd2,
    CFG_SPIKE_RATIO  = 3'd3,
    CFG_FRAME_PERIOD = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_BR_S, S_BR_X, S_BV_S, S_BV_X, S_FR_S, S_FR_X, S_FR_W,
    S_DECIDE, S_IDEN, S_IDIV, S_SM_S, S_SM_X, S_SC0, S_SC1, S_SC2,
    S_SC3, S_SDIV, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_BR_S, OP_BR_X, OP_BV_S, OP_BV_X, OP_FR_S, OP_FR_X,
    OP_FR_W, OP_DECIDE, OP_IDEN, OP_INST, OP_SM_S, OP_SM_X, OP_SC0, OP_SC1,
    OP_SC2, OP_SC3, OP_SPCT, OP_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fast_gt;
    logic scream;
    logic div_done;
    logic out_full;
  } status_t;

  function automatic logic [6:0] cap100(input logic [DIV_W-1:0] v);
    cap100 = (v > DIV_W'(100)) ? 7'd100 : v[6:0];
  endfunction

  function automatic logic [6:0] laugh_pct(input logic [LAUGH_W-1:0] c);
    logic [6:0] r;
    case (c)
      5'd0:    r = 7'd0;
      5'd1:    r = 7'd6;
      5'd2:    r = 7'd13;
      5'd3:    r = 7'd20;
      5'd4:    r = 7'd26;
      5'd5:    r = 7'd33;
      5'd6:    r = 7'd40;
      5'd7:    r = 7'd46;
      5'd8:    r = 7'd53;
      5'd9:    r = 7'd60;
      5'd10:   r = 7'd66;
      5'd11:   r = 7'd73;
      5'd12:   r = 7'd80;
      5'd13:   r = 7'd86;
      5'd14:   r = 7'd93;
      default: r = 7'd100;
    endcase
    laugh_pct = r;
  endfunction

  function automatic logic [6:0] react_pct(input logic [SUSTAIN_BITS-1:0] c);
    logic [6:0] r;
    case (c)
      16'd0:   r = 7'd0;
      16'd1:   r = 7'd5;
      16'd2:   r = 7'd11;
      16'd3:   r = 7'd16;
      16'd4:   r = 7'd22;
      16'd5:   r = 7'd27;
      16'd6:   r = 7'd33;
      16'd7:   r = 7'd38;
      16'd8:   r = 7'd44;
      16'd9:   r = 7'd50;
      16'd10:  r = 7'd55;
      16'd11:  r = 7'd61;
      16'd12:  r = 7'd66;
      16'd13:  r = 7'd72;
      16'd14:  r = 7'd77;
      16'd15:  r = 7'd83;
      16'd16:  r = 7'd88;
      16'd17:  r = 7'd94;
      default: r = 7'd100;
    endcase
    react_pct = r;
  endfunction

endpackage

>>> hdl/audio_excitement_scorer.sv
// ----------------------------------------------------------------------------
// Audio excitement scorer
// Scores audio frame features for loudness, excitement, peaks, screams, laughter and reaction.
// ----------------------------------------------------------------------------
// One frame word is taken at a time, and a frame holds the block until its
// result is loaded. A frame whose fast level exceeds the baseline needs a
// divide for its instant score; one whose fast level stays at or below the
// baseline does not. A scream skips three score steps. A frame uses up to
// thirteen steps on one shared multiplier and one or two 48-step runs of the
// shared serial divider, each of which is waited on. The result word waits in
// an output register, so the next frame is accepted while the previous result
// is still stalled; a frame that finishes while that register is still full
// waits for it.
module audio_excitement_scorer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_rms_level,
  input  logic [15:0] in_voice_energy,
  input  logic [15:0] in_high_energy,
  input  logic [15:0] in_peak_level,
  input  logic [15:0] in_crossing_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_level_pct,
  output logic [6:0]  out_excitement_pct,
  output logic [6:0]  out_peak_pct,
  output logic [6:0]  out_scream_pct,
  output logic [6:0]  out_laughter_pct,
  output logic [6:0]  out_reaction_pct,
  output logic [23:0] out_sustained_ms
);

  aes_pkg::cmd_t    cmd;
  aes_pkg::status_t status;

  aes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  aes_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_rms_level       (in_rms_level),
    .in_voice_energy    (in_voice_energy),
    .in_high_energy     (in_high_energy),
    .in_peak_level      (in_peak_level),
    .in_crossing_rate   (in_crossing_rate),
    .cmd                (cmd),
    .status             (status),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_level_pct      (out_level_pct),
    .out_excitement_pct (out_excitement_pct),
    .out_peak_pct       (out_peak_pct),
    .out_scream_pct     (out_scream_pct),
    .out_laughter_pct   (out_laughter_pct),
    .out_reaction_pct   (out_reaction_pct),
    .out_sustained_ms   (out_sustained_ms)
  );

endmodule

>>> hdl/aes_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aes_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [aes_pkg::DIV_W-1:0]  num,
  input  logic [aes_pkg::DIV_W-1:0]  den,
  output logic                       done,
  output logic [aes_pkg::DIV_W-1:0]  quot
);

  logic                          busy_r;
  logic                          done_r;
  logic [aes_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [aes_pkg::DIV_W:0]       rem_r;
  logic [aes_pkg::DIV_W-1:0]     q_r;
  logic [aes_pkg::DIV_W-1:0]     den_r;
  logic [aes_pkg::DIV_W:0]       trial;
  logic                          fits;

  assign trial = {rem_r[aes_pkg::DIV_W-1:0], q_r[aes_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        q_r    <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
        q_r   <= {q_r[aes_pkg::DIV_W-2:0], fits};
        cnt_r <= cnt_r + aes_pkg::DIV_CNT_W'(1);
        if (cnt_r == aes_pkg::DIV_CNT_W'(aes_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("done without a run");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < {1'b0, den_r}) else $error("remainder not reduced");

endmodule

>>> hdl/aes_ctrl.sv
// ----------------------------------------------------------------------------
// Scorer controller
// Sequences one frame through the shared multiplier and divider steps.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  aes_pkg::status_t status,
  output aes_pkg::cmd_t    cmd
);

  aes_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = aes_pkg::OP_NONE;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    in_stall      = 1'b1;
    case (state_r)
      aes_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = aes_pkg::OP_LOAD;
          state_nxt = aes_pkg::S_BR_S;
        end
      end
      aes_pkg::S_BR_S: begin
        cmd.op = aes_pkg::OP_BR_S; state_nxt = aes_pkg::S_BR_X;
      end
      aes_pkg::S_BR_X: begin
        cmd.op = aes_pkg::OP_BR_X; state_nxt = aes_pkg::S_BV_S;
      end
      aes_pkg::S_BV_S: begin
        cmd.op = aes_pkg::OP_BV_S; state_nxt = aes_pkg::S_BV_X;
      end
      aes_pkg::S_BV_X: begin
        cmd.op = aes_pkg::OP_BV_X; state_nxt = aes_pkg::S_FR_S;
      end
      aes_pkg::S_FR_S: begin
        cmd.op = aes_pkg::OP_FR_S; state_nxt = aes_pkg::S_FR_X;
      end
      aes_pkg::S_FR_X: begin
        cmd.op = aes_pkg::OP_FR_X; state_nxt = aes_pkg::S_FR_W;
      end
      aes_pkg::S_FR_W: begin
        cmd.op = aes_pkg::OP_FR_W; state_nxt = aes_pkg::S_DECIDE;
      end
      aes_pkg::S_DECIDE: begin
        cmd.op = aes_pkg::OP_DECIDE; state_nxt = aes_pkg::S_IDEN;
      end
      aes_pkg::S_IDEN: begin
        cmd.op = aes_pkg::OP_IDEN;
        if (status.fast_gt) begin
          cmd.div_start = 1'b1;
          state_nxt     = aes_pkg::S_IDIV;
        end else begin
          state_nxt = aes_pkg::S_SM_S;
        end
      end
      aes_pkg::S_IDIV: begin
        if (status.div_done) begin
          cmd.op    = aes_pkg::OP_INST;
          state_nxt = aes_pkg::S_SM_S;
        end
      end
      aes_pkg::S_SM_S: begin
        cmd.op = aes_pkg::OP_SM_S; state_nxt = aes_pkg::S_SM_X;
      end
      aes_pkg::S_SM_X: begin
        cmd.op = aes_pkg::OP_SM_X; state_nxt = aes_pkg::S_SC0;
      end
      aes_pkg::S_SC0: begin
        cmd.op = aes_pkg::OP_SC0;
        if (status.scream) begin
          cmd.div_start = 1'b1;
          state_nxt     = aes_pkg::S_SDIV;
        end else begin
          state_nxt = aes_pkg::S_SC1;
        end
      end
      aes_pkg::S_SC1: begin
        cmd.op = aes_pkg::OP_SC1; state_nxt = aes_pkg::S_SC2;
      end
      aes_pkg::S_SC2: begin
        cmd.op = aes_pkg::OP_SC2; state_nxt = aes_pkg::S_SC3;
      end
      aes_pkg::S_SC3: begin
        cmd.op        = aes_pkg::OP_SC3;
        cmd.div_start = 1'b1;
        state_nxt     = aes_pkg::S_SDIV;
      end
      aes_pkg::S_SDIV: begin
        if (status.div_done) begin
          cmd.op    = aes_pkg::OP_SPCT;
          state_nxt = aes_pkg::S_FIN;
        end
      end
      aes_pkg::S_FIN: begin
        if (!status.out_full) begin
          cmd.op       = aes_pkg::OP_FIN;
          cmd.out_load = 1'b1;
          state_nxt    = aes_pkg::S_IDLE;
        end
      end
      default: state_nxt = aes_pkg::S_IDLE;
    endcase
  end

  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !status.out_full) else $error("result word overwritten");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == aes_pkg::S_IDIV || state_r == aes_pkg::S_SDIV))
    else $error("divider started outside a wait step");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == aes_pkg::S_BR_S)
    else $error("accepted word not sequenced");

endmodule

>>> hdl/aes_dp.sv
// ----------------------------------------------------------------------------
// Scorer datapath
// Holds configuration, frame state, the shared multiplier and the result word.
// ----------------------------------------------------------------------------
module aes_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic [15:0]      in_rms_level,
  input  logic [15:0]      in_voice_energy,
  input  logic [15:0]      in_high_energy,
  input  logic [15:0]      in_peak_level,
  input  logic [15:0]      in_crossing_rate,
  input  aes_pkg::cmd_t    cmd,
  output aes_pkg::status_t status,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [6:0]       out_level_pct,
  output logic [6:0]       out_excitement_pct,
  output logic [6:0]       out_peak_pct,
  output logic [6:0]       out_scream_pct,
  output logic [6:0]       out_laughter_pct,
  output logic [6:0]       out_reaction_pct,
  output logic [23:0]      out_sustained_ms
);

  localparam int QW = aes_pkg::Q_W;
  localparam int DW = aes_pkg::DIV_W;
  localparam int PW = aes_pkg::MP_W;

  logic [15:0] slow_alpha_r, fast_alpha_r, smooth_alpha_r;
  logic [11:0] spike_ratio_r;
  logic [7:0]  frame_period_r;

  logic [15:0] rms_r, voice_r, high_r, peak_r, zcr_r, prev_zcr_r;
  logic [QW-1:0] bl_rms_r, bl_voice_r, fast_r, smooth_r, instant_r;
  logic [QW-1:0] base_r, vden_r;
  logic [aes_pkg::LAUGH_W-1:0] laugh_r;
  logic [aes_pkg::SUSTAIN_BITS-1:0] sus_r;
  logic fast_gt_r, scream_r;
  logic [PW-1:0] prod_r, acc_r;
  logic [DW-1:0] num_r;
  logic [6:0] spct_r;
  logic out_valid_r;

  logic [aes_pkg::MA_W-1:0] mul_a;
  logic [aes_pkg::MB_W-1:0] mul_b;
  logic [PW-1:0] ema_sum;
  logic [QW-1:0] ema_val, base_c, vden_c, csa, cfa, cma;
  logic [15:0] zd;
  logic burst_c, spike_c, scream_c;
  logic [11:0] sr1;
  logic [DW-1:0] div_num, div_den, div_q, p48;
  logic div_done;

  assign csa     = QW'(aes_pkg::ONE_Q - {1'b0, slow_alpha_r});
  assign cfa     = QW'(aes_pkg::ONE_Q - {1'b0, fast_alpha_r});
  assign cma     = QW'(aes_pkg::ONE_Q - {1'b0, smooth_alpha_r});
  assign ema_sum = acc_r + prod_r;
  assign ema_val = ema_sum[aes_pkg::FRAC_BITS+QW-1:aes_pkg::FRAC_BITS];
  assign base_c  = (bl_rms_r > aes_pkg::BASE_FLOOR) ? bl_rms_r : aes_pkg::BASE_FLOOR;
  assign vden_c  = ({1'b0, voice_r} > aes_pkg::VOICE_FLOOR) ? {1'b0, voice_r}
                                                           : aes_pkg::VOICE_FLOOR;
  assign zd      = (zcr_r > prev_zcr_r) ? zcr_r - prev_zcr_r : prev_zcr_r - zcr_r;
  assign burst_c = ((21'(voice_r) * 21'd5) > (21'(bl_voice_r) * 21'd9)) &&
                   ((21'(zd) * 21'd20) > 21'd65536);
  assign spike_c = ((PW'({1'b0, fast_r} + {1'b0, base_r}) << 8) > prod_r) &&
                   ({2'b0, voice_r} > {bl_voice_r, 1'b0});
  assign scream_c = spike_c && ((19'(high_r) * 19'd5) > (19'(vden_r) * 19'd3)) &&
                    (peak_r > 16'd32768);
  assign sr1     = (spike_ratio_r == 12'd0) ? 12'd1 : spike_ratio_r;
  assign p48     = DW'(prod_r);

  function automatic logic [QW-1:0] inst_fix(input logic [DW-1:0] q, input logic scr);
    logic [QW-1:0] v;
    v = (q > DW'(aes_pkg::ONE_Q)) ? aes_pkg::ONE_Q : q[QW-1:0];
    if (scr && v < aes_pkg::HIGH_EXCITE) begin
      v = aes_pkg::HIGH_EXCITE;
    end
    inst_fix = v;
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      aes_pkg::OP_BR_S:   begin mul_a = 32'(bl_rms_r);   mul_b = csa; end
      aes_pkg::OP_BR_X:   begin mul_a = 32'(rms_r);      mul_b = {1'b0, slow_alpha_r}; end
      aes_pkg::OP_BV_S:   begin mul_a = 32'(bl_voice_r); mul_b = csa; end
      aes_pkg::OP_BV_X:   begin mul_a = 32'(voice_r);    mul_b = {1'b0, slow_alpha_r}; end
      aes_pkg::OP_FR_S:   begin mul_a = 32'(fast_r);     mul_b = cfa; end
      aes_pkg::OP_FR_X:   begin mul_a = 32'(rms_r);      mul_b = {1'b0, fast_alpha_r}; end
      aes_pkg::OP_DECIDE: begin
        mul_a = 32'(base_c);
        mul_b = {5'b0, spike_ratio_r} + 17'd256;
      end
      aes_pkg::OP_SM_S:   begin mul_a = 32'(smooth_r);   mul_b = cma; end
      aes_pkg::OP_SM_X:   begin mul_a = 32'(instant_r);  mul_b = {1'b0, smooth_alpha_r}; end
      aes_pkg::OP_SC0:    begin mul_a = 32'(high_r);     mul_b = fast_r; end
      aes_pkg::OP_SC1:    begin mul_a = 32'(vden_r);     mul_b = base_r; end
      aes_pkg::OP_SC2:    begin mul_a = prod_r[31:0];    mul_b = {5'b0, sr1}; end
      aes_pkg::OP_SPCT:   begin mul_a = 32'(sus_r);      mul_b = {9'b0, frame_period_r}; end
      default: ;
    endcase
  end

  always_comb begin
    div_num = num_r;
    div_den = p48;
    case (cmd.op)
      aes_pkg::OP_IDEN: begin
        div_num = DW'(fast_r - base_r) << 24;
        div_den = p48;
      end
      aes_pkg::OP_SC0: begin
        div_num = DW'(high_r) * DW'(20);
        div_den = DW'(vden_r);
      end
      default: ;
    endcase
  end

  aes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_alpha_r   <= 16'd98;
      fast_alpha_r   <= 16'd16384;
      smooth_alpha_r <= 16'd9830;
      spike_ratio_r  <= 12'd768;
      frame_period_r <= 8'd20;
      bl_rms_r       <= '0;
      bl_voice_r     <= '0;
      fast_r         <= '0;
      smooth_r       <= '0;
      prev_zcr_r     <= '0;
      laugh_r        <= '0;
      sus_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aes_pkg::CFG_SLOW_ALPHA:   slow_alpha_r   <= cfg_data;
          aes_pkg::CFG_FAST_ALPHA:   fast_alpha_r   <= cfg_data;
          aes_pkg::CFG_SMOOTH_ALPHA: smooth_alpha_r <= cfg_data;
          aes_pkg::CFG_SPIKE_RATIO:  spike_ratio_r  <= cfg_data[11:0];
          aes_pkg::CFG_FRAME_PERIOD: frame_period_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        aes_pkg::OP_BV_S: bl_rms_r   <= ema_val;
        aes_pkg::OP_FR_S: bl_voice_r <= ema_val;
        aes_pkg::OP_FR_W: fast_r     <= ema_val;
        aes_pkg::OP_SC0:  smooth_r   <= ema_val;
        aes_pkg::OP_DECIDE: begin
          prev_zcr_r <= zcr_r;
          if (burst_c) begin
            laugh_r <= (laugh_r >= aes_pkg::LAUGH_LIMIT) ? aes_pkg::LAUGH_LIMIT
                                                         : laugh_r + aes_pkg::LAUGH_W'(1);
          end else begin
            laugh_r <= (laugh_r > 5'd2) ? laugh_r - 5'd2 : 5'd0;
          end
        end
        aes_pkg::OP_IDEN: begin
          if (spike_c || laugh_r >= aes_pkg::LAUGH_SUSTAIN) begin
            if (sus_r != aes_pkg::SUSTAIN_MAX) begin
              sus_r <= sus_r + aes_pkg::SUSTAIN_BITS'(1);
            end
          end else if (sus_r != '0) begin
            sus_r <= sus_r - aes_pkg::SUSTAIN_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op inside {aes_pkg::OP_BR_S, aes_pkg::OP_BR_X, aes_pkg::OP_BV_S,
                       aes_pkg::OP_BV_X, aes_pkg::OP_FR_S, aes_pkg::OP_FR_X,
                       aes_pkg::OP_DECIDE, aes_pkg::OP_SM_S, aes_pkg::OP_SM_X,
                       aes_pkg::OP_SC0, aes_pkg::OP_SC1, aes_pkg::OP_SC2,
                       aes_pkg::OP_SPCT}) begin
      prod_r <= PW'(mul_a) * PW'(mul_b);
    end
    case (cmd.op)
      aes_pkg::OP_LOAD: begin
        rms_r   <= in_rms_level;
        voice_r <= in_voice_energy;
        high_r  <= in_high_energy;
        peak_r  <= in_peak_level;
        zcr_r   <= in_crossing_rate;
      end
      aes_pkg::OP_BR_X, aes_pkg::OP_BV_X, aes_pkg::OP_FR_X, aes_pkg::OP_SM_X: begin
        acc_r <= prod_r;
      end
      aes_pkg::OP_DECIDE: begin
        base_r    <= base_c;
        vden_r    <= vden_c;
        fast_gt_r <= fast_r > base_c;
      end
      aes_pkg::OP_IDEN: begin
        scream_r <= scream_c;
        if (!fast_gt_r) begin
          instant_r <= inst_fix('0, scream_c);
        end
      end
      aes_pkg::OP_INST: instant_r <= inst_fix(div_q, scream_r);
      aes_pkg::OP_SC1:  num_r <= (p48 << 13) + (p48 << 12) + (p48 << 9);
      aes_pkg::OP_SPCT: begin
        if (scream_r) begin
          spct_r <= (div_q > DW'(100)) ? 7'd100
                    : aes_pkg::cap100(div_q + DW'(80));
        end else begin
          spct_r <= aes_pkg::cap100(div_q);
        end
      end
      aes_pkg::OP_FIN: begin
        out_level_pct      <= aes_pkg::cap100(DW'((25'(rms_r) * 25'd400) >> 16));
        out_excitement_pct <= aes_pkg::cap100(DW'((24'(smooth_r) * 24'd100) >> 16));
        out_peak_pct       <= aes_pkg::cap100(DW'((24'(peak_r) * 24'd100) >> 16));
        out_scream_pct     <= spct_r;
        out_laughter_pct   <= aes_pkg::laugh_pct(laugh_r);
        out_reaction_pct   <= aes_pkg::react_pct(sus_r);
        out_sustained_ms   <= (prod_r > PW'(24'hFFFFFF)) ? 24'hFFFFFF : prod_r[23:0];
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign status.fast_gt  = fast_gt_r;
  assign status.scream   = scream_r;
  assign status.div_done = div_done;
  assign status.out_full = out_valid_r && out_stall;

endmodule
